>>> design/cas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_pkg
// Shared types and codes for the clamp alignment sequencer: action codes,
// step numbers, configuration register indexes and the records that pass
// between the input stage, the register file and the step logic.
// ----------------------------------------------------------------------------
package cas_pkg;

  localparam int TimeW   = 32;
  localparam int SpeedW  = 20;
  localparam int TargetW = 32;
  localparam int ActionW = 3;
  localparam int StepW   = 4;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  // Action codes reported with each result
  localparam logic [ActionW-1:0] ACT_NONE    = 3'd0;
  localparam logic [ActionW-1:0] ACT_MOVE    = 3'd1;
  localparam logic [ActionW-1:0] ACT_EXTEND  = 3'd2;
  localparam logic [ActionW-1:0] ACT_LEFT    = 3'd3;
  localparam logic [ActionW-1:0] ACT_RETRACT = 3'd4;
  localparam logic [ActionW-1:0] ACT_RIGHT   = 3'd5;
  localparam logic [ActionW-1:0] ACT_DONE    = 3'd6;
  localparam logic [ActionW-1:0] ACT_ABORT   = 3'd7;

  // Sequence steps
  localparam logic [StepW-1:0] STEP_MOVE        = 4'd0;
  localparam logic [StepW-1:0] STEP_WAIT_MOTOR  = 4'd1;
  localparam logic [StepW-1:0] STEP_EXTEND      = 4'd2;
  localparam logic [StepW-1:0] STEP_PRE_DWELL   = 4'd3;
  localparam logic [StepW-1:0] STEP_LEFT        = 4'd4;
  localparam logic [StepW-1:0] STEP_HOLD_DWELL  = 4'd5;
  localparam logic [StepW-1:0] STEP_RETRACT     = 4'd6;
  localparam logic [StepW-1:0] STEP_AFTER_DWELL = 4'd7;
  localparam logic [StepW-1:0] STEP_RIGHT       = 4'd8;
  localparam logic [StepW-1:0] STEP_SETTLE      = 4'd9;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MOVE_SPEED    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MOVE_TARGET   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRE_EXTEND    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HOLD_EXTENDED = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_AFTER_RETRACT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SETTLE        = 3'd5;

  typedef struct packed {
    logic        [SpeedW-1:0]  move_speed_hz;
    logic signed [TargetW-1:0] move_target_steps;
    logic        [TimeW-1:0]   pre_extend_ms;
    logic        [TimeW-1:0]   hold_extended_ms;
    logic        [TimeW-1:0]   after_retract_ms;
    logic        [TimeW-1:0]   settle_ms;
  } cas_cfg_t;

  typedef struct packed {
    logic             valid;
    logic [TimeW-1:0] now_ms;
    logic             start_pressed;
    logic             motor_running;
  } cas_req_t;

endpackage

>>> design/cas_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_if
// Valid/ready channels of the sequencer: polling calls in, one result per
// call out, and the configuration write channel.
// ----------------------------------------------------------------------------
interface cas_item_if;
  import cas_pkg::*;
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] now_ms;
  logic             start_pressed;
  logic             motor_running;

  modport source (output valid, output now_ms, output start_pressed,
                  output motor_running, input ready);
  modport sink   (input valid, input now_ms, input start_pressed,
                  input motor_running, output ready);
endinterface

interface cas_result_if;
  import cas_pkg::*;
  logic                      valid;
  logic                      ready;
  logic        [ActionW-1:0] action;
  logic        [SpeedW-1:0]  move_speed;
  logic signed [TargetW-1:0] move_target;
  logic        [StepW-1:0]   step_now;

  modport source (output valid, output action, output move_speed,
                  output move_target, output step_now, input ready);
  modport sink   (input valid, input action, input move_speed,
                  input move_target, input step_now, output ready);
endinterface

interface cas_cfg_if;
  import cas_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/clamp_alignment_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamp_alignment_sequencer
// Ten-step clamp and alignment sequencer polled once per input beat.
// ----------------------------------------------------------------------------
// Each polling beat yields exactly one result beat carrying the action code,
// the move command fields (nonzero only with a start-move action) and the
// step index after the call. The block takes one beat per clock while the
// result channel does not stall: a beat is held in the input register, is
// evaluated by the step logic while it moves into the result register, and
// is then presented on the result channel from the result register. The
// step state is updated as each beat enters the result register, so
// back-to-back beats see each other's effects.
// A stalled result channel holds the pipeline; up to two beats are then
// buffered. Configuration writes are taken every cycle and belong in idle
// periods; the result of a start press is an abort that clears the sequence.
module clamp_alignment_sequencer
  import cas_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  cas_cfg_if.sink       cfg,
  cas_item_if.sink      item,
  cas_result_if.source  result
);

  cas_cfg_t regs;
  cas_req_t req;
  logic     consume;

  cas_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  cas_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .consume (consume),
    .req     (req)
  );

  cas_step_core u_step_core (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .req     (req),
    .consume (consume),
    .result  (result)
  );

endmodule

>>> design/cas_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_cfg_regs
// Configuration register file. Takes one write beat per cycle; indexes past
// the last register are accepted and dropped.
// ----------------------------------------------------------------------------
module cas_cfg_regs
  import cas_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  cas_cfg_if.sink  cfg,
  output cas_cfg_t regs
);

  assign cfg.ready = 1'b1;

  // Store a write beat into the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MOVE_SPEED:    regs.move_speed_hz     <= cfg.data[SpeedW-1:0];
        REG_MOVE_TARGET:   regs.move_target_steps <= signed'(cfg.data[TargetW-1:0]);
        REG_PRE_EXTEND:    regs.pre_extend_ms     <= cfg.data[TimeW-1:0];
        REG_HOLD_EXTENDED: regs.hold_extended_ms  <= cfg.data[TimeW-1:0];
        REG_AFTER_RETRACT: regs.after_retract_ms  <= cfg.data[TimeW-1:0];
        REG_SETTLE:        regs.settle_ms         <= cfg.data[TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/cas_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_in_stage
// Input register for polling calls. Holds one beat and refills in the same
// cycle that the step logic consumes it.
// ----------------------------------------------------------------------------
module cas_in_stage
  import cas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  cas_item_if.sink  item,
  input  logic      consume,
  output cas_req_t  req
);

  logic take;

  assign item.ready = !req.valid || consume;
  assign take       = item.valid && item.ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (take) begin
      req.valid <= 1'b1;
    end else if (consume) begin
      req.valid <= 1'b0;
    end
  end

  // Capture the payload of an accepted beat
  always_ff @(posedge clk) begin
    if (take) begin
      req.now_ms        <= item.now_ms;
      req.start_pressed <= item.start_pressed;
      req.motor_running <= item.motor_running;
    end
  end

endmodule

>>> design/cas_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_step_core
// Step index and step timestamp, the per-call decision logic and the result
// register. One call is evaluated each cycle that the result register can
// take it.
// ----------------------------------------------------------------------------
module cas_step_core
  import cas_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cas_cfg_t      regs,
  input  cas_req_t      req,
  output logic          consume,
  cas_result_if.source  result
);

  logic [StepW-1:0]   step_index;
  logic [TimeW-1:0]   step_start_ms;
  logic [StepW-1:0]   step_index_next;
  logic [TimeW-1:0]   step_start_ms_next;
  logic [ActionW-1:0] action_next;
  logic [TimeW-1:0]   dwell_limit;
  logic [TimeW-1:0]   dwell_age;
  logic               dwell_over;
  logic               is_move;

  assign consume = req.valid && (!result.valid || result.ready);

  // Pick the dwell limit for the current step
  always_comb begin
    unique case (step_index)
      STEP_PRE_DWELL:   dwell_limit = regs.pre_extend_ms;
      STEP_HOLD_DWELL:  dwell_limit = regs.hold_extended_ms;
      STEP_AFTER_DWELL: dwell_limit = regs.after_retract_ms;
      default:          dwell_limit = regs.settle_ms;
    endcase
  end

  // Wrapping age of the current step
  assign dwell_age  = req.now_ms - step_start_ms;
  assign dwell_over = dwell_age >= dwell_limit;

  // Decide the action and the next step for this call
  always_comb begin
    step_index_next    = step_index;
    step_start_ms_next = step_start_ms;
    action_next        = ACT_NONE;
    if (req.start_pressed) begin
      step_index_next    = '0;
      step_start_ms_next = '0;
      action_next        = ACT_ABORT;
    end else begin
      unique case (step_index)
        STEP_MOVE, STEP_EXTEND, STEP_LEFT, STEP_RETRACT, STEP_RIGHT: begin
          step_index_next    = step_index + StepW'(1);
          step_start_ms_next = req.now_ms;
          unique case (step_index)
            STEP_MOVE:    action_next = ACT_MOVE;
            STEP_EXTEND:  action_next = ACT_EXTEND;
            STEP_LEFT:    action_next = ACT_LEFT;
            STEP_RETRACT: action_next = ACT_RETRACT;
            default:      action_next = ACT_RIGHT;
          endcase
        end
        STEP_WAIT_MOTOR: begin
          if (!req.motor_running) begin
            step_index_next    = step_index + StepW'(1);
            step_start_ms_next = req.now_ms;
          end
        end
        STEP_PRE_DWELL, STEP_HOLD_DWELL, STEP_AFTER_DWELL: begin
          if (dwell_over) begin
            step_index_next    = step_index + StepW'(1);
            step_start_ms_next = req.now_ms;
          end
        end
        STEP_SETTLE: begin
          if (dwell_over) begin
            step_index_next    = '0;
            step_start_ms_next = '0;
            action_next        = ACT_DONE;
          end
        end
        default: begin
          // unreachable step numbers fall back to the start
          step_index_next    = '0;
          step_start_ms_next = '0;
        end
      endcase
    end
  end

  assign is_move = action_next == ACT_MOVE;

  // Advance sequence state on each consumed call
  always_ff @(posedge clk) begin
    if (rst) begin
      step_index    <= '0;
      step_start_ms <= '0;
    end else if (consume) begin
      step_index    <= step_index_next;
      step_start_ms <= step_start_ms_next;
    end
  end

  // Hold the result beat until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (consume) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      result.action      <= action_next;
      result.move_speed  <= is_move ? regs.move_speed_hz : '0;
      result.move_target <= is_move ? regs.move_target_steps : '0;
      result.step_now    <= step_index_next;
    end
  end

endmodule
